// ===== src/pttf_pkg.sv =====
// Package for the programmable transition table FSM: widths, codes and shared types.
package pttf_pkg;

  localparam int STATE_W     = 4;
  localparam int SYM_W       = 4;
  localparam int OP_W        = 3;
  localparam int ERR_W       = 3;
  localparam int NUM_STATES  = 1 << STATE_W;
  localparam int NUM_SYMBOLS = 1 << SYM_W;
  localparam int TT_AW       = STATE_W + SYM_W;
  localparam int TT_DEPTH    = NUM_STATES * NUM_SYMBOLS;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_STATE = 3'd0,
    OP_ADD_TRANS = 3'd1,
    OP_SET_CUR   = 3'd2,
    OP_STEP      = 3'd3,
    OP_READ_CUR  = 3'd4
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK            = 3'd0,
    ERR_NO_STATES     = 3'd1,
    ERR_STATE_MISSING = 3'd2,
    ERR_STATE_EXISTS  = 3'd3,
    ERR_TRANS_EXISTS  = 3'd4,
    ERR_TRANS_MISSING = 3'd5
  } err_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the item and read the table
    logic exec;      // resolve the item, update stores, load the result register
  } ctl_cmd_t;

endpackage

// ===== src/pttf_req_if.sv =====
// Request channel: one FSM operation per transfer.
interface pttf_req_if
  import pttf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [STATE_W-1:0] state_id;
  logic [STATE_W-1:0] target_state;
  logic [SYM_W-1:0]   symbol;

  modport source (output valid, op, state_id, target_state, symbol, input ready);
  modport sink   (input valid, op, state_id, target_state, symbol, output ready);
endinterface

// ===== src/pttf_rsp_if.sv =====
// Response channel: current state and error code for each request.
interface pttf_rsp_if
  import pttf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] current_state;
  logic [ERR_W-1:0]   error_code;
  logic               has_states;

  modport source (output valid, current_state, error_code, has_states, input ready);
  modport sink   (input valid, current_state, error_code, has_states, output ready);
endinterface

// ===== src/pttf_datapath.sv =====
// Datapath: state bitmap, transition table, current state and the result register.
module pttf_datapath
  import pttf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  input  logic [OP_W-1:0]    op,
  input  logic [STATE_W-1:0] state_id,
  input  logic [STATE_W-1:0] target_state,
  input  logic [SYM_W-1:0]   symbol,
  output logic [STATE_W-1:0] current_state,
  output logic [ERR_W-1:0]   error_code,
  output logic               has_states
);

  logic [STATE_W-1:0] tt_mem [TT_DEPTH];
  logic [TT_DEPTH-1:0]   tt_valid;
  logic [NUM_STATES-1:0] state_present;
  logic [STATE_W-1:0]    cur;
  logic [STATE_W-1:0]    cur_next;
  logic                  any_state;
  logic                  any_state_next;

  logic [OP_W-1:0]    op_q;
  logic [STATE_W-1:0] sid_q;
  logic [STATE_W-1:0] tgt_q;
  logic [TT_AW-1:0]   addr_q;
  logic [STATE_W-1:0] rd_end;
  logic [TT_AW-1:0]   rd_addr;

  err_t err;
  logic set_present;
  logic tt_write;

  // A step looks up the current state, everything else the given start state
  assign rd_addr = (op_t'(op) == OP_STEP) ? {cur, symbol} : {state_id, symbol};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      sid_q  <= state_id;
      tgt_q  <= target_state;
      addr_q <= rd_addr;
      rd_end <= tt_mem[rd_addr];
    end
    if (cmd.exec && tt_write) begin
      tt_mem[addr_q] <= tgt_q;
    end
  end

  always_comb begin
    err            = ERR_OK;
    cur_next       = cur;
    any_state_next = any_state;
    set_present    = 1'b0;
    tt_write       = 1'b0;
    unique case (op_t'(op_q))
      OP_ADD_STATE: begin
        if (state_present[sid_q]) begin
          err = ERR_STATE_EXISTS;
        end else begin
          set_present    = 1'b1;
          any_state_next = 1'b1;
          if (!any_state) cur_next = sid_q;
        end
      end
      OP_ADD_TRANS: begin
        if (!state_present[sid_q] || !state_present[tgt_q]) begin
          err = ERR_STATE_MISSING;
        end else if (tt_valid[addr_q]) begin
          err = ERR_TRANS_EXISTS;
        end else begin
          tt_write = 1'b1;
        end
      end
      OP_SET_CUR: begin
        if (state_present[sid_q]) cur_next = sid_q;
        else err = ERR_STATE_MISSING;
      end
      OP_STEP: begin
        if (!any_state) err = ERR_NO_STATES;
        else if (!tt_valid[addr_q]) err = ERR_TRANS_MISSING;
        else cur_next = rd_end;
      end
      default: begin
        if (!any_state) err = ERR_NO_STATES;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tt_valid      <= '0;
      state_present <= '0;
      cur           <= '0;
      any_state     <= 1'b0;
    end else if (cmd.exec) begin
      cur       <= cur_next;
      any_state <= any_state_next;
      if (set_present) state_present[sid_q] <= 1'b1;
      if (tt_write) tt_valid[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      current_state <= any_state_next ? cur_next : '0;
      error_code    <= err;
      has_states    <= any_state_next;
    end
  end

endmodule

// ===== src/pttf_ctrl.sv =====
// Controller: sequences capture and execute, and owns the result valid flag.
module pttf_ctrl
  import pttf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ctl_cmd_t cmd
);

  ctl_state_t state, state_next;
  logic       rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      CS_IDLE: begin
        // refuse transfers while reset is held
        req_ready   = !rst;
        cmd.capture = req_valid && req_ready;
        if (req_valid && req_ready) state_next = CS_EXEC;
      end
      CS_EXEC: begin
        // hold until the result register is free or being emptied
        if (!rsp_valid || rsp_ready) begin
          cmd.exec   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
    rsp_valid_next = (rsp_valid && !rsp_ready) || cmd.exec;
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == CS_EXEC && !req_ready)
    else $error("accepted request did not enter execute");

  a_exec_stalls: assert property (@(posedge clk) disable iff (rst)
    state == CS_EXEC && rsp_valid && !rsp_ready |=> state == CS_EXEC)
    else $error("execute overwrote a pending result");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == CS_EXEC)
    else $error("result appeared without an execute cycle");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !cmd.exec |=> !rsp_valid)
    else $error("result repeated after transfer");

endmodule

// ===== src/programmable_transition_table_fsm.sv =====
// Programmable table-driven FSM: top level joining controller and datapath.
//
// Channels: req carries one operation per transfer (op, state_id,
// target_state, symbol); rsp returns exactly one result per request
// (current_state, error_code, has_states). Both use valid/ready and a
// transfer happens when both are high on a rising edge of clk.
// Sequence: the request is captured with the table read, then resolved and
// loaded into the result register, which can leave when rsp is not stalled.
// A new request is accepted only after the current one has executed; the
// transition table is a memory with registered read, so each item first
// reads the table entry and then resolves and writes back.
// The next request is taken while a result still waits in the output
// register; execution of that request holds until the register drains.
// Reset (rst, synchronous, active high) clears the state bitmap, all
// transition valid bits, the current state and the has-states flag, and
// empties the output register; req is not ready while rst is high and the
// block takes a request the cycle after.
// A stalled rsp holds its payload and valid unchanged.
module programmable_transition_table_fsm
  import pttf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  pttf_req_if.sink   req,
  pttf_rsp_if.source rsp
);

  ctl_cmd_t cmd;

  pttf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  pttf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (req.op),
    .state_id      (req.state_id),
    .target_state  (req.target_state),
    .symbol        (req.symbol),
    .current_state (rsp.current_state),
    .error_code    (rsp.error_code),
    .has_states    (rsp.has_states)
  );

endmodule
